// ----- sv/act_pkg.sv -----
package act_pkg;

   localparam int MAX_ENTRIES    = 32;
   localparam int SIGNATURE_BITS = 64;
   localparam int MASK_W         = 64;
   localparam int ENTRY_W        = 5;
   localparam int DEP_W          = 32;
   localparam int IDX_W          = $clog2(MAX_ENTRIES);
   localparam int CNT_W          = $clog2(MAX_ENTRIES + 1);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      op_type                    op;
      logic [SIGNATURE_BITS-1:0] rd;
      logic [SIGNATURE_BITS-1:0] wr;
   } cmd_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] entry_index;
      logic [DEP_W-1:0]   dependency_vector;
      logic               accepted;
   } rsp_type;

endpackage

// ----- sv/act_front.sv -----
module act_front
   import act_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_cmd,
   input  logic [MASK_W-1:0]   req_read_mask,
   input  logic [MASK_W-1:0]   req_write_mask,
   output logic                cmd_valid,
   input  logic                cmd_pop,
   output cmd_type             cmd
);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push_ok;
   logic                pop_ok;
   cmd_type             new_cmd;

   always_comb begin
      new_cmd.op = req_cmd ? OP_CLEAR : OP_ADD;
      new_cmd.rd = req_read_mask[SIGNATURE_BITS-1:0];
      new_cmd.wr = req_write_mask[SIGNATURE_BITS-1:0];
   end

   assign req_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- sv/act_back.sv -----
module act_back
   import act_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_pop,
   output rsp_type rsp
);

   logic [SIGNATURE_BITS-1:0] read_mem  [MAX_ENTRIES];
   logic [SIGNATURE_BITS-1:0] write_mem [MAX_ENTRIES];
   logic [SIGNATURE_BITS-1:0] st_rd_ff;
   logic [SIGNATURE_BITS-1:0] st_wr_ff;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [IDX_W-1:0]          cmp_idx_ff;
   logic                      cmp_valid_ff, cmp_valid_in;
   logic [SIGNATURE_BITS-1:0] rd_ff, rd_in;
   logic [SIGNATURE_BITS-1:0] wr_ff, wr_in;
   logic [DEP_W-1:0]          dep_ff, dep_in;
   rsp_type                   res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      mem_we;
   logic                      conflict;
   logic                      last_idx;

   assign conflict = |((st_wr_ff & wr_ff) | (st_wr_ff & rd_ff) | (st_rd_ff & wr_ff));
   assign last_idx = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmp_valid_in = 1'b0;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      dep_in       = dep_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;

      if (cmp_valid_ff && conflict) begin
         dep_in = dep_ff | (DEP_W'(1) << cmp_idx_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               rd_in   = cmd.rd;
               wr_in   = cmd.wr;
               dep_in  = '0;
               idx_in  = '0;
               if (cmd.op == OP_CLEAR) begin
                  count_in = '0;
                  res_in   = '{entry_index: '0, dependency_vector: '0, accepted: 1'b1};
                  state_in = ST_EMIT;
               end else if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                  res_in   = '{entry_index: '0, dependency_vector: '0, accepted: 1'b0};
                  state_in = ST_EMIT;
               end else if (count_ff == '0) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmp_valid_in = 1'b1;
            if (last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
            res_in   = '{entry_index:       ENTRY_W'(count_ff),
                         dependency_vector: dep_ff,
                         accepted:          1'b1};
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= idx_ff;
      rd_ff      <= rd_in;
      wr_ff      <= wr_in;
      dep_ff     <= dep_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         read_mem[count_ff[IDX_W-1:0]]  <= rd_ff;
         write_mem[count_ff[IDX_W-1:0]] <= wr_ff;
      end
      st_rd_ff <= read_mem[idx_ff];
      st_wr_ff <= write_mem[idx_ff];
   end

endmodule

// ----- sv/access_conflict_dependency_tracker_top.sv -----
// Read/write hazard tracker. Each add transaction stores a read mask and a
// write mask in the next free slot and returns a vector with one bit for every
// earlier slot whose accesses conflict with it (write/write, write/read or
// read/write). A clear transaction empties the table. An add to a full table
// is refused with accepted low.
// Requests enter through a queue interface (req_push, req_full) into a
// two-deep command queue; results leave through a queue interface (rsp_empty,
// rsp_pop) from a one-deep result register.
// An add walks the stored entries in the execution engine at one slot per
// cycle, then drains the compare pipeline, writes the new entry to the next
// free slot and emits the result; the walk is skipped when the table is empty.
// A clear or a refused add goes straight to emit. The result is registered
// onto the result ports, where it waits until the receiver pops it.
// Reset empties the table and both queues. While the receiver does not pop,
// the engine holds its next result and stops, and the command queue accepts
// up to two more transactions before req_full rises.
module access_conflict_dependency_tracker_top
   import act_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_cmd,
   input  logic [MASK_W-1:0]   req_read_mask,
   input  logic [MASK_W-1:0]   req_write_mask,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [ENTRY_W-1:0]  rsp_entry_index,
   output logic [DEP_W-1:0]    rsp_dependency_vector,
   output logic                rsp_accepted
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   logic    rsp_valid;
   rsp_type rsp;

   act_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_read_mask  (req_read_mask),
      .req_write_mask (req_write_mask),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop),
      .cmd            (cmd)
   );

   act_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_empty             = !rsp_valid;
   assign rsp_entry_index       = rsp.entry_index;
   assign rsp_dependency_vector = rsp.dependency_vector;
   assign rsp_accepted          = rsp.accepted;

endmodule
